/* rtl/hcaf_pkg.sv */
// Package for the hypervisor CSR access filter: beat structs, CSR numbers,
// opcode codes and the stored hstatus field layout.
// No dependencies.
package hcaf_pkg;

  // Access opcode
  localparam logic OpRead  = 1'b0;
  localparam logic OpWrite = 1'b1;

  // Hypervisor CSR numbers
  localparam logic [11:0] CsrHstatus    = 12'h600;
  localparam logic [11:0] CsrHypLo      = 12'h60A;
  localparam logic [11:0] CsrHyp2First  = 12'h643;
  localparam logic [11:0] CsrHyp2Last   = 12'h64A;
  localparam logic [11:0] CsrHgatp      = 12'h680;
  localparam logic [11:0] CsrHgeip      = 12'hE12;

  // VS shadow range
  localparam logic [11:0] CsrVsFirst    = 12'h200;
  localparam logic [11:0] CsrVsLast     = 12'h244;
  localparam logic [11:0] CsrVsatp      = 12'h280;

  // Supervisor CSRs renamed while virtualized
  localparam logic [11:0] CsrSstatus    = 12'h100;
  localparam logic [11:0] CsrSie        = 12'h104;
  localparam logic [11:0] CsrStvec      = 12'h105;
  localparam logic [11:0] CsrScounteren = 12'h106;
  localparam logic [11:0] CsrSscratch   = 12'h140;
  localparam logic [11:0] CsrSepc       = 12'h141;
  localparam logic [11:0] CsrScause     = 12'h142;
  localparam logic [11:0] CsrStval      = 12'h143;
  localparam logic [11:0] CsrSip        = 12'h144;
  localparam logic [11:0] CsrSatp       = 12'h180;

  // VS shadow = supervisor number plus 0x100
  localparam logic [11:0] VsOffset      = 12'h100;

  localparam logic [1:0] VsxlFixed      = 2'd2;
  localparam logic [1:0] HupmmReserved  = 2'b01;

  typedef struct packed {
    logic        opcode;
    logic [11:0] csr_number;
    logic        virtualized;
    logic [63:0] write_value;
  } hcaf_in_t;

  typedef struct packed {
    logic [11:0] mapped_csr;
    logic        virtual_instruction;
    logic        hits_hstatus;
    logic [63:0] read_data;
  } hcaf_out_t;

  // Only the writable hstatus fields are kept
  typedef struct packed {
    logic [1:0] hupmm;  // bits 49:48
    logic       vtsr;   // bit 22
    logic       vtw;    // bit 21
    logic       vtvm;   // bit 20
    logic       hu;     // bit 9
    logic       spvp;   // bit 8
    logic       spv;    // bit 7
    logic       gva;    // bit 6
  } hstatus_t;

endpackage

/* rtl/hypervisor_csr_access_filter.sv */
// Top level of the hypervisor CSR access filter: VS renaming, virtual
// instruction check and the hstatus register. Depends on hcaf_pkg.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o/in_data_i) carries one CSR access a
//   beat; output channel (out_valid_o/out_ready_i/out_data_o) returns one
//   result beat per access, in order.
//   cfg_we_i/cfg_wdata_i set pointer masking; write only while idle.
//   The input register loads at the accept edge; the result register loads
//   when the access leaves the input register, which a stalled receiver holds off.
//   Throughput: one access per cycle while the receiver does not stall; the decode
//   and the hstatus update sit in the single logic stage between the registers.
//   hstatus is updated when an access leaves the input register, so a later
//   access always sees the effect of earlier ones.
//   Reset clears hstatus, pointer masking and both valid flags.
//   When the receiver stalls, the result register holds; the input register
//   still takes one more beat, then in_ready_o drops until out_ready_i rises.
module hypervisor_csr_access_filter
  import hcaf_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  hcaf_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output hcaf_out_t out_data_o,
  input  logic      cfg_we_i,
  input  logic      cfg_wdata_i
);

  logic      pm_en_q;
  hstatus_t  hstatus_q, hstatus_d;
  logic      s1_valid_q;
  hcaf_in_t  s1_data_q;
  logic      out_valid_q;
  hcaf_out_t out_data_q, out_data_d;

  logic      s1_advance;
  logic      in_fire;
  logic [11:0] num;
  logic [11:0] mapped;
  logic      is_hyp, is_shadow, vinst, hit;
  hstatus_t  masked;
  hstatus_t  upd;

  assign s1_advance = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_advance;
  assign in_fire    = in_valid_i && in_ready_o;

  assign num = s1_data_q.csr_number;

  always_comb begin
    mapped = num;
    if (s1_data_q.virtualized) begin
      unique case (num)
        CsrSstatus, CsrSie, CsrStvec, CsrScounteren, CsrSscratch,
        CsrSepc, CsrScause, CsrStval, CsrSip, CsrSatp: mapped = num + VsOffset;
        default: mapped = num;
      endcase
    end
  end

  // Check uses the number as issued
  assign is_hyp = (num >= CsrHstatus && num <= CsrHypLo) ||
                  (num >= CsrHyp2First && num <= CsrHyp2Last) ||
                  (num == CsrHgatp) || (num == CsrHgeip);
  assign is_shadow = (num >= CsrVsFirst && num <= CsrVsLast) || (num == CsrVsatp);
  assign vinst = s1_data_q.virtualized && (is_hyp || is_shadow);
  assign hit   = (mapped == CsrHstatus) && !vinst;

  always_comb begin
    masked       = hstatus_q;
    masked.hupmm = hstatus_q.hupmm & {2{pm_en_q}};

    upd.hupmm = s1_data_q.write_value[49:48] & {2{pm_en_q}};
    upd.vtsr  = s1_data_q.write_value[22];
    upd.vtw   = s1_data_q.write_value[21];
    upd.vtvm  = s1_data_q.write_value[20];
    upd.hu    = s1_data_q.write_value[9];
    upd.spvp  = s1_data_q.write_value[8];
    upd.spv   = s1_data_q.write_value[7];
    upd.gva   = s1_data_q.write_value[6];
    // reserved HUPMM encoding leaves the field alone
    if (upd.hupmm == HupmmReserved) begin
      upd.hupmm = hstatus_q.hupmm;
    end

    hstatus_d = hstatus_q;
    if (s1_advance && hit && s1_data_q.opcode == OpWrite) begin
      hstatus_d = upd;
    end
  end

  always_comb begin
    out_data_d.mapped_csr          = mapped;
    out_data_d.virtual_instruction = vinst;
    out_data_d.hits_hstatus        = hit;
    out_data_d.read_data           = '0;
    if (hit && s1_data_q.opcode == OpRead) begin
      out_data_d.read_data[49:48] = masked.hupmm;
      out_data_d.read_data[33:32] = VsxlFixed;
      out_data_d.read_data[22]    = masked.vtsr;
      out_data_d.read_data[21]    = masked.vtw;
      out_data_d.read_data[20]    = masked.vtvm;
      out_data_d.read_data[9]     = masked.hu;
      out_data_d.read_data[8]     = masked.spvp;
      out_data_d.read_data[7]     = masked.spv;
      out_data_d.read_data[6]     = masked.gva;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pm_en_q     <= 1'b0;
      hstatus_q   <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        pm_en_q <= cfg_wdata_i;
      end
      hstatus_q <= hstatus_d;
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (s1_advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_data_q <= in_data_i;
    end
    if (s1_advance) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // hstatus changes only on a write beat that hits it
  a_state_only_on_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s1_advance && hit && s1_data_q.opcode == OpWrite) |=> $stable(hstatus_q))
    else $error("hstatus changed without a hitting write");

  a_reserved_never_stored: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hstatus_q.hupmm != HupmmReserved)
    else $error("reserved HUPMM value stored");

  a_fault_no_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.virtual_instruction |-> !out_data_o.hits_hstatus)
    else $error("faulted access marked as hstatus hit");

  a_rdata_needs_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.read_data != '0) |-> out_data_o.hits_hstatus)
    else $error("read data without hstatus hit");

  a_no_drop_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && out_valid_q && !out_ready_i |=> s1_valid_q && out_valid_q)
    else $error("beat lost under stall");

endmodule
